// ===== hdl/hard_decision_constellation_demapper_macros.svh =====
// Assertion helpers shared by the demapper checker.
`ifndef HARD_DECISION_CONSTELLATION_DEMAPPER_MACROS_SVH
`define HARD_DECISION_CONSTELLATION_DEMAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HDCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HDCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hdcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hdcd_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned MAX_POINTS_DEF   = 64;
    localparam int unsigned SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned BPS_W   = 3;
    localparam int unsigned OUT_W   = 8;

    // bits_per_symbol register
    localparam logic [BPS_W-1:0] BPS_RESET = 3'd2;
    localparam logic [BPS_W-1:0] BPS_MIN   = 3'd1;
    localparam logic [BPS_W-1:0] BPS_MAX   = 3'd6;

    // Request kinds carried on tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DEMAP = 1'b1;

    // Control that travels alongside one distance evaluation
    typedef struct packed {
        logic valid;
        logic last;
    } dist_tag_t;

endpackage

`default_nettype wire

// ===== hdl/hdcd_point_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hdcd_point_mem #(
    parameter int unsigned DEPTH = hdcd_pkg::MAX_POINTS_DEF,
    parameter int unsigned WIDTH = 2 * hdcd_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hdcd_dist_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Squared Euclidean distance, three stages: difference, square, sum.
module hdcd_dist_unit #(
    parameter int unsigned SAMPLE_WIDTH = hdcd_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire hdcd_pkg::dist_tag_t              tag_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   point_i,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   point_q,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   samp_i,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   samp_q,
    output hdcd_pkg::dist_tag_t                   tag_out,
    output logic             [2*SAMPLE_WIDTH+1:0] sq_dist
);

    localparam int unsigned DW = SAMPLE_WIDTH + 1;
    localparam int unsigned SW = 2 * SAMPLE_WIDTH + 1;

    hdcd_pkg::dist_tag_t tag_d_reg, tag_s_reg, tag_o_reg;

    logic signed [DW-1:0]   diff_i_next, diff_q_next;
    logic signed [DW-1:0]   diff_i_reg, diff_q_reg;
    logic signed [2*DW-1:0] prod_i, prod_q;
    logic        [SW-1:0]   sq_i_reg, sq_q_reg;
    logic        [SW:0]     sum_reg;

    assign diff_i_next = DW'(samp_i) - DW'(point_i);
    assign diff_q_next = DW'(samp_q) - DW'(point_q);
    assign prod_i      = diff_i_reg * diff_i_reg;
    assign prod_q      = diff_q_reg * diff_q_reg;

    // Tag pipeline follows the data stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_d_reg <= '0;
            tag_s_reg <= '0;
            tag_o_reg <= '0;
        end else begin
            tag_d_reg <= tag_in;
            tag_s_reg <= tag_d_reg;
            tag_o_reg <= tag_s_reg;
        end
    end

    // Datapath: squares are non-negative, so the top product bit is dropped
    always_ff @(posedge aclk) begin
        diff_i_reg <= diff_i_next;
        diff_q_reg <= diff_q_next;
        sq_i_reg   <= prod_i[SW-1:0];
        sq_q_reg   <= prod_q[SW-1:0];
        sum_reg    <= {1'b0, sq_i_reg} + {1'b0, sq_q_reg};
    end

    assign tag_out = tag_o_reg;
    assign sq_dist = sum_reg;

endmodule

`default_nettype wire

// ===== hdl/hard_decision_constellation_demapper.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Minimum-distance hard-decision demapper. A load request (tuser = 0) writes one
// constellation point into the point table and leaves the input ready. A demap request
// (tuser = 1) searches the first N = min(2^bits_per_symbol, MAX_POINTS) points
// for the one nearest the sample (lowest index wins a tie) and then sends the
// index MSB first, one bit per output request, tlast on the final bit. The search
// runs one point per cycle through a single shared distance unit (table read,
// difference, square, sum, compare); the input stays not-ready from the demap
// request until the last bit has been loaded into the output register.
// bits_per_symbol (reset 2) is written on the cfg port by the user, who must do so
// only while idle; the block itself does not enforce this. 0 acts as 1 and 7 as 6.
// Demapping against a table entry that was never loaded gives an arbitrary index.
module hard_decision_constellation_demapper #(
    parameter int unsigned MAX_POINTS   = hdcd_pkg::MAX_POINTS_DEF,
    parameter int unsigned SAMPLE_WIDTH = hdcd_pkg::SAMPLE_WIDTH_DEF,
    localparam int unsigned DATA_W =
        ((hdcd_pkg::INDEX_W + 2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config write
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [hdcd_pkg::BPS_W-1:0]      cfg_data,     // bits_per_symbol
    // request stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [DATA_W-1:0]               s_axis_tdata, // point_index, in_phase, quadrature
    input  wire logic                            s_axis_tuser, // op
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [hdcd_pkg::OUT_W-1:0]           m_axis_tdata, // bit_value
    output logic                                 m_axis_tlast  // last_bit
);

    localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
    localparam int unsigned DIST_W = 2 * SAMPLE_WIDTH + 2;
    localparam int unsigned LUT_N  = 2 ** hdcd_pkg::INDEX_W;
    localparam logic [8:0]  TOP_ADDR = 9'(MAX_POINTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Request fields
    logic                                   s_accept;
    logic [hdcd_pkg::INDEX_W-1:0]           in_index;
    logic signed [SAMPLE_WIDTH-1:0]         in_i, in_q;

    assign in_index = s_axis_tdata[hdcd_pkg::INDEX_W-1:0];
    assign in_i     = s_axis_tdata[hdcd_pkg::INDEX_W +: SAMPLE_WIDTH];
    assign in_q     = s_axis_tdata[hdcd_pkg::INDEX_W + SAMPLE_WIDTH +: SAMPLE_WIDTH];
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // Load index wraps modulo the table depth
    logic [IDX_W-1:0] wrap_lut [LUT_N];
    for (genvar g = 0; g < LUT_N; g++) begin : g_wrap
        assign wrap_lut[g] = IDX_W'(g % MAX_POINTS);
    end

    // Configuration register
    logic [hdcd_pkg::BPS_W-1:0] bps_reg;
    logic [hdcd_pkg::BPS_W-1:0] bps_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bps_reg <= hdcd_pkg::BPS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            bps_reg <= cfg_data;
        end
    end

    always_comb begin
        if (bps_reg < hdcd_pkg::BPS_MIN) begin
            bps_eff = hdcd_pkg::BPS_MIN;
        end else if (bps_reg > hdcd_pkg::BPS_MAX) begin
            bps_eff = hdcd_pkg::BPS_MAX;
        end else begin
            bps_eff = bps_reg;
        end
    end

    // Last table address to search
    logic [8:0]       span_full;
    logic [IDX_W-1:0] last_addr_next;

    assign span_full      = 9'((9'd1 << bps_eff) - 9'd1);
    assign last_addr_next = IDX_W'((span_full > TOP_ADDR) ? TOP_ADDR : span_full);

    // Per-request registers
    logic [hdcd_pkg::BPS_W-1:0]     nbits_reg;
    logic [IDX_W-1:0]               last_addr_reg;
    logic signed [SAMPLE_WIDTH-1:0] samp_i_reg, samp_q_reg;

    always_ff @(posedge aclk) begin
        if (s_accept && s_axis_tuser == hdcd_pkg::OP_DEMAP) begin
            nbits_reg     <= bps_eff;
            last_addr_reg <= last_addr_next;
            samp_i_reg    <= in_i;
            samp_q_reg    <= in_q;
        end
    end

    // Point table
    logic                       mem_wr_en;
    logic                       mem_rd_en;
    logic [2*SAMPLE_WIDTH-1:0]  mem_rd_data;
    logic [IDX_W-1:0]           addr_reg, addr_next;

    assign mem_wr_en = s_accept && s_axis_tuser == hdcd_pkg::OP_LOAD;
    assign mem_rd_en = (state_reg == ST_SEARCH);

    hdcd_point_mem #(
        .DEPTH (MAX_POINTS),
        .WIDTH (2 * SAMPLE_WIDTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (wrap_lut[in_index]),
        .wr_data ({in_q, in_i}),
        .rd_en   (mem_rd_en),
        .rd_addr (addr_reg),
        .rd_data (mem_rd_data)
    );

    // Tag for the read in flight, aligned to the memory latency
    hdcd_pkg::dist_tag_t issue_tag, rd_tag_reg, dist_tag;
    logic [DIST_W-1:0]   sq_dist;

    assign issue_tag.valid = mem_rd_en;
    assign issue_tag.last  = mem_rd_en && (addr_reg == last_addr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_tag_reg <= '0;
        end else begin
            rd_tag_reg <= issue_tag;
        end
    end

    hdcd_dist_unit #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag_in  (rd_tag_reg),
        .point_i (mem_rd_data[SAMPLE_WIDTH-1:0]),
        .point_q (mem_rd_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .samp_i  (samp_i_reg),
        .samp_q  (samp_q_reg),
        .tag_out (dist_tag),
        .sq_dist (sq_dist)
    );

    // Running minimum; strict less-than keeps the lowest index on a tie
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [DIST_W-1:0] best_dist_reg;
    logic              take_new;

    assign take_new = dist_tag.valid && ((cmp_idx_reg == '0) || (sq_dist < best_dist_reg));
    assign best_idx_next = take_new ? cmp_idx_reg : best_idx_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            cmp_idx_reg <= '0;
        end else if (dist_tag.valid) begin
            cmp_idx_reg <= cmp_idx_reg + 1'b1;
        end
        if (take_new) begin
            best_dist_reg <= sq_dist;
        end
        best_idx_reg <= best_idx_next;
    end

    // Output serializer
    logic [hdcd_pkg::INDEX_W-1:0] best_word;
    logic [hdcd_pkg::BPS_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         m_bit_reg, m_bit_next;
    logic                         m_last_reg, m_last_next;
    logic                         out_free;

    assign best_word = hdcd_pkg::INDEX_W'(best_idx_reg);
    assign out_free  = !m_valid_reg || m_axis_tready;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        bit_cnt_next = bit_cnt_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_bit_next   = m_bit_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                addr_next = '0;
                if (s_accept && s_axis_tuser == hdcd_pkg::OP_DEMAP) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == last_addr_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (dist_tag.valid && dist_tag.last) begin
                    bit_cnt_next = nbits_reg - 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_bit_next   = best_word[bit_cnt_reg];
                    m_last_next  = (bit_cnt_reg == '0);
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                    if (bit_cnt_reg == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        bit_cnt_reg <= bit_cnt_next;
        m_bit_reg   <= m_bit_next;
        m_last_reg  <= m_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = hdcd_pkg::OUT_W'(m_bit_reg);
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== hdl/hdcd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "hard_decision_constellation_demapper_macros.svh"

module hdcd_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic                        s_axis_tuser,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [hdcd_pkg::OUT_W-1:0]  m_axis_tdata,
    input wire logic                        m_axis_tlast
);

    logic s_acc;
    logic m_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    // A stalled result holds
    `HDCD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // A demap request starts a search, so the input goes busy
    `HDCD_ASSERT_NXT(a_demap_busy, aclk, aresetn, s_acc && s_axis_tuser == hdcd_pkg::OP_DEMAP, !s_axis_tready, "input ready right after a demap request")

    // A load request leaves the input ready in the following cycle
    `HDCD_ASSERT_NXT(a_load_ready, aclk, aresetn, s_acc && s_axis_tuser == hdcd_pkg::OP_LOAD, s_axis_tready, "input busy after a load request")

    // No bit can follow the final bit of a symbol at once
    `HDCD_ASSERT_NXT(a_gap_after_last, aclk, aresetn, m_acc && m_axis_tlast, !m_axis_tvalid, "result right after the last bit")

endmodule

bind hard_decision_constellation_demapper hdcd_checker u_hdcd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/hard_decision_constellation_demapper_tb.sv =====
`timescale 1ns / 1ps

module hard_decision_constellation_demapper_tb;

    localparam int unsigned S_DATA_W   =
        ((hdcd_pkg::INDEX_W + 2 * hdcd_pkg::SAMPLE_WIDTH_DEF + 7) / 8) * 8;
    localparam int unsigned TABLE_SIZE = hdcd_pkg::MAX_POINTS_DEF;
    localparam int unsigned MAX_GAP    = 6;
    localparam int unsigned SETTLE     = 80;  // search of 64 points plus pipeline
    localparam int unsigned MAX_SHOWN  = 10;

    // One index bit as it should leave the block
    typedef struct {
        logic bit_value;
        logic last_bit;
    } index_bit_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [hdcd_pkg::BPS_W-1:0]    cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [S_DATA_W-1:0]           s_axis_tdata;   // point_index, in_phase, quadrature
    logic                          s_axis_tuser;   // op
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [hdcd_pkg::OUT_W-1:0]    m_axis_tdata;   // bit_value
    logic                          m_axis_tlast;   // last_bit

    // Shadow of the block's state
    logic signed [15:0]            const_i [TABLE_SIZE];
    logic signed [15:0]            const_q [TABLE_SIZE];
    logic [hdcd_pkg::BPS_W-1:0]    bps_shadow;

    index_bit_t          pending_bits [$];
    index_bit_t          head_bit;
    int unsigned         fault_count;
    bit                  steady_flow;

    hard_decision_constellation_demapper DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("hard_decision_constellation_demapper_tb failed");
        $finish;
    end

    function automatic int unsigned draw_gap();
        if (steady_flow)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Nearest-point search over the active points, index queued MSB first
    function automatic void predict_nearest(logic signed [15:0] si, logic signed [15:0] sq);
        int unsigned    nbits;
        int unsigned    count;
        int unsigned    best;
        longint         di;
        longint         dq;
        longint         dist_sq;
        longint         best_dist;
        index_bit_t     b;
        nbits = 32'(bps_shadow);
        if (nbits < hdcd_pkg::BPS_MIN)
            nbits = 32'(hdcd_pkg::BPS_MIN);
        if (nbits > hdcd_pkg::BPS_MAX)
            nbits = 32'(hdcd_pkg::BPS_MAX);
        count = 1 << nbits;
        if (count > TABLE_SIZE)
            count = TABLE_SIZE;
        best = 0;
        best_dist = 0;
        for (int unsigned k = 0; k < count; k++) begin
            di = longint'(si) - longint'(const_i[k]);
            dq = longint'(sq) - longint'(const_q[k]);
            dist_sq = di * di + dq * dq;
            // strict compare keeps the lowest index on a tie
            if (k == 0 || dist_sq < best_dist) begin
                best_dist = dist_sq;
                best = k;
            end
        end
        for (int j = int'(nbits) - 1; j >= 0; j--) begin
            b.bit_value = best[j];
            b.last_bit  = (j == 0);
            pending_bits.push_back(b);
        end
    endfunction

    // Send one request after a random gap; tvalid stays high if the next follows at once
    task automatic send_request(input logic op, input logic [5:0] idx,
                                input logic signed [15:0] i_val,
                                input logic signed [15:0] q_val);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(S_DATA_W - hdcd_pkg::INDEX_W - 32){1'b0}}, q_val, i_val, idx};
        do @(posedge aclk); while (!s_axis_tready);
        if (op == hdcd_pkg::OP_LOAD) begin
            const_i[idx] = i_val;
            const_q[idx] = q_val;
        end else begin
            predict_nearest(i_val, q_val);
        end
    endtask

    task automatic drop_valid();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        drop_valid();
        while (pending_bits.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Register write, only once the block has gone quiet
    task automatic write_bps(input logic [hdcd_pkg::BPS_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bps_shadow = value;
    endtask

    // Result sink with random stalls
    initial begin
        int unsigned hold;
        m_axis_tready = 1'b0;
        while (aresetn !== 1'b1)
            @(posedge aclk);
        forever begin
            hold = draw_gap();
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // Compare every accepted result with the oldest expected bit
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_bits.size() == 0) begin
                if (fault_count < MAX_SHOWN)
                    $display("%0t: unexpected result tdata=%h tlast=%b",
                             $realtime, m_axis_tdata, m_axis_tlast);
                fault_count++;
            end else begin
                head_bit = pending_bits.pop_front();
                if (m_axis_tdata !== {{(hdcd_pkg::OUT_W - 1){1'b0}}, head_bit.bit_value}) begin
                    if (fault_count < MAX_SHOWN)
                        $display("%0t: bit_value expected %h got %h", $realtime,
                                 {{(hdcd_pkg::OUT_W - 1){1'b0}}, head_bit.bit_value},
                                 m_axis_tdata);
                    fault_count++;
                end
                if (m_axis_tlast !== head_bit.last_bit) begin
                    if (fault_count < MAX_SHOWN)
                        $display("%0t: last_bit expected %b got %b", $realtime,
                                 head_bit.last_bit, m_axis_tlast);
                    fault_count++;
                end
            end
        end
    end

    // Fill every table entry with an 8x8 grid, entries 0 and 63 moved to the field extremes
    task automatic test_table_fill();
        logic signed [15:0] gi;
        logic signed [15:0] gq;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            gi = 16'(-28672 + (k % 8) * 8192);
            gq = 16'(-28672 + (k / 8) * 8192);
            if (k == 0) begin
                gi = -16'sd32768;
                gq = -16'sd32768;
            end
            if (k == TABLE_SIZE - 1) begin
                gi = 16'sd32767;
                gq = 16'sd32767;
            end
            send_request(hdcd_pkg::OP_LOAD, k[5:0], gi, gq);
        end
    endtask

    // Demaps at the reset setting, samples at the field extremes and at zero
    task automatic test_reset_setting();
        send_request(hdcd_pkg::OP_DEMAP, 6'd0,  -16'sd32768, -16'sd32768);
        send_request(hdcd_pkg::OP_DEMAP, 6'd63,  16'sd32767,  16'sd32767);
        send_request(hdcd_pkg::OP_DEMAP, 6'd0,   16'sd0,      16'sd0);
        send_request(hdcd_pkg::OP_DEMAP, 6'd21, -16'sd32768,  16'sd32767);
        send_request(hdcd_pkg::OP_DEMAP, 6'd42,  16'sd32767, -16'sd32768);
    endtask

    // Equal distances: the lower index must win
    task automatic test_ties();
        send_request(hdcd_pkg::OP_LOAD,  6'd0, -16'sd16384, 16'sd16384);
        send_request(hdcd_pkg::OP_LOAD,  6'd1, -16'sd16384, 16'sd16384);
        send_request(hdcd_pkg::OP_LOAD,  6'd2,  16'sd12000, -16'sd5000);
        send_request(hdcd_pkg::OP_LOAD,  6'd3,  16'sd12000,  16'sd5000);
        send_request(hdcd_pkg::OP_DEMAP, 6'd0, -16'sd16384, 16'sd16384);
        send_request(hdcd_pkg::OP_DEMAP, 6'd0,  16'sd12000, 16'sd0);
        send_request(hdcd_pkg::OP_DEMAP, 6'd0,  16'sd12000, 16'sd5000);
    endtask

    // Every register value, 0 and 7 included, one demap each
    task automatic test_bps_sweep();
        for (int v = 0; v < 8; v++) begin
            write_bps(v[hdcd_pkg::BPS_W-1:0]);
            send_request(hdcd_pkg::OP_DEMAP, 6'h3f, 16'($urandom), 16'($urandom));
        end
    endtask

    // Mostly demaps, near active points or of raw samples, plus reloads
    task automatic test_random_traffic();
        int unsigned        nbits;
        int unsigned        k;
        int                 vi;
        int                 vq;
        logic [5:0]         idx;
        for (int phase = 0; phase < 7; phase++) begin
            write_bps(hdcd_pkg::BPS_W'($urandom_range(0, 7)));
            steady_flow = ($urandom_range(0, 3) == 0);
            nbits = (bps_shadow < hdcd_pkg::BPS_MIN) ? 32'(hdcd_pkg::BPS_MIN) :
                    (bps_shadow > hdcd_pkg::BPS_MAX) ? 32'(hdcd_pkg::BPS_MAX) :
                    32'(bps_shadow);
            for (int n = 0; n < 18; n++) begin
                case ($urandom_range(0, 7))
                    0: begin
                        send_request(hdcd_pkg::OP_LOAD, 6'($urandom), 16'($urandom),
                                     16'($urandom));
                    end
                    1: begin
                        // copy of another entry sets up a tie
                        k = $urandom_range(0, (1 << nbits) - 1);
                        idx = 6'($urandom_range(0, (1 << nbits) - 1));
                        send_request(hdcd_pkg::OP_LOAD, idx, const_i[k], const_q[k]);
                    end
                    2, 3: begin
                        send_request(hdcd_pkg::OP_DEMAP, 6'($urandom), 16'($urandom),
                                     16'($urandom));
                    end
                    default: begin
                        k = $urandom_range(0, (1 << nbits) - 1);
                        vi = int'(const_i[k]) + $urandom_range(0, 1200) - 600;
                        vq = int'(const_q[k]) + $urandom_range(0, 1200) - 600;
                        vi = (vi > 32767) ? 32767 : (vi < -32768) ? -32768 : vi;
                        vq = (vq > 32767) ? 32767 : (vq < -32768) ? -32768 : vq;
                        send_request(hdcd_pkg::OP_DEMAP, 6'($urandom), 16'(vi), 16'(vq));
                    end
                endcase
            end
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = hdcd_pkg::OP_LOAD;
        fault_count   = 0;
        steady_flow   = 1'b0;
        bps_shadow    = hdcd_pkg::BPS_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_table_fill();
        test_reset_setting();
        test_ties();
        test_bps_sweep();
        test_random_traffic();

        drain_results();
        if (fault_count == 0) begin
            $display("hard_decision_constellation_demapper_tb passed");
        end else begin
            $display("hard_decision_constellation_demapper_tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hdcd_pkg.sv
hdl/hdcd_point_mem.sv
hdl/hdcd_dist_unit.sv
hdl/hard_decision_constellation_demapper.sv
hdl/hdcd_checker.sv
verif/hard_decision_constellation_demapper_tb.sv
